### design/vtc_pkg.sv
// Package for the voxel to chunk-local coordinate unit.
// Shared widths, register indexes, reset values and the lane result type.
package vtc_pkg;

   localparam int CFG_W            = 8;
   localparam int COORD_W          = 32;
   localparam int LOCAL_W          = 8;
   localparam int CSR_IDX_W        = 3;
   localparam int NUM_AXES         = 3;
   localparam int COORD_WIDTH_DEF  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TERRAIN_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TERRAIN_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TERRAIN_Z = 3'd5;

   localparam logic [CFG_W-1:0] CHUNK_RESET   = 8'd16;
   localparam logic [CFG_W-1:0] TERRAIN_RESET = 8'd16;

   typedef struct packed {
      logic               valid;
      logic [LOCAL_W-1:0] local_c;
      logic [COORD_W-1:0] home;
   } lane_out_type;

endpackage

### design/vtc_channels.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on vtc_pkg for field widths.
interface vtc_req_if;
   logic                        valid;
   logic                        ready;
   logic [vtc_pkg::COORD_W-1:0] voxel_x;
   logic [vtc_pkg::COORD_W-1:0] voxel_y;
   logic [vtc_pkg::COORD_W-1:0] voxel_z;
   logic [vtc_pkg::COORD_W-1:0] grid_x;
   logic [vtc_pkg::COORD_W-1:0] grid_y;
   logic [vtc_pkg::COORD_W-1:0] grid_z;

   modport source (output valid, voxel_x, voxel_y, voxel_z, grid_x, grid_y, grid_z,
                   input ready);
   modport sink (input valid, voxel_x, voxel_y, voxel_z, grid_x, grid_y, grid_z,
                 output ready);
endinterface

interface vtc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vtc_pkg::LOCAL_W-1:0] local_x;
   logic [vtc_pkg::LOCAL_W-1:0] local_y;
   logic [vtc_pkg::LOCAL_W-1:0] local_z;
   logic [vtc_pkg::COORD_W-1:0] home_chunk_x;
   logic [vtc_pkg::COORD_W-1:0] home_chunk_y;
   logic [vtc_pkg::COORD_W-1:0] home_chunk_z;

   modport source (output valid, local_x, local_y, local_z,
                   home_chunk_x, home_chunk_y, home_chunk_z, input ready);
   modport sink (input valid, local_x, local_y, local_z,
                 home_chunk_x, home_chunk_y, home_chunk_z, output ready);
endinterface

### design/voxel_to_chunk_local_coord_unit.sv
// Top level of the voxel to chunk-local coordinate unit: register file,
// three axis lanes (vtc_lane) and the merged response register. Uses vtc_pkg.
//
// Usage:
//   req_bus carries one beat per item: voxel and grid coordinates, three axes.
//   rsp_bus returns one beat per item: local_x/y/z and home_chunk_x/y/z.
//   csr_we/csr_index/csr_wdata write the six 8-bit size registers; indexes
//   above five are dropped. Write them only while no item is in flight.
// Throughput: one beat per cycle. Every stage advances together; the pipe
//   moves whenever the response register is empty or being taken.
// Depth: set by the two bit-per-stage divider pipes of each lane, COORD_WIDTH
//   stages for the floor division and 16 for the scaling division.
// Stall: while rsp_bus.ready is low with a beat waiting, the whole pipe holds
//   and req_bus.ready is low; nothing is dropped.
// Reset: synchronous, active high; clears all valid bits, sizes return to 16.
module voxel_to_chunk_local_coord_unit #(
   parameter int COORD_WIDTH = vtc_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vtc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vtc_pkg::CFG_W-1:0]       csr_wdata,
   vtc_req_if.sink                         req_bus,
   vtc_rsp_if.source                       rsp_bus
);
   import vtc_pkg::*;

   logic [CFG_W-1:0] chunk_ff   [NUM_AXES];
   logic [CFG_W-1:0] terrain_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            chunk_ff[i]   <= CHUNK_RESET;
            terrain_ff[i] <= TERRAIN_RESET;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_CHUNK_X:   chunk_ff[0]   <= csr_wdata;
            REG_CHUNK_Y:   chunk_ff[1]   <= csr_wdata;
            REG_CHUNK_Z:   chunk_ff[2]   <= csr_wdata;
            REG_TERRAIN_X: terrain_ff[0] <= csr_wdata;
            REG_TERRAIN_Y: terrain_ff[1] <= csr_wdata;
            REG_TERRAIN_Z: terrain_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                rsp_valid_ff;
   logic                en;
   logic [COORD_W-1:0]  voxel [NUM_AXES];
   logic [COORD_W-1:0]  grid  [NUM_AXES];
   lane_out_type        lane_out [NUM_AXES];

   assign en              = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready   = en;

   assign voxel[0] = req_bus.voxel_x;
   assign voxel[1] = req_bus.voxel_y;
   assign voxel[2] = req_bus.voxel_z;
   assign grid[0]  = req_bus.grid_x;
   assign grid[1]  = req_bus.grid_y;
   assign grid[2]  = req_bus.grid_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      logic [CFG_W-1:0] chunk_eff, terrain_eff;
      // a size of zero counts as one
      assign chunk_eff   = (chunk_ff[a]   == '0) ? 8'd1 : chunk_ff[a];
      assign terrain_eff = (terrain_ff[a] == '0) ? 8'd1 : terrain_ff[a];

      vtc_lane #(.W(COORD_WIDTH)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (req_bus.valid),
         .voxel    (voxel[a]),
         .grid     (grid[a]),
         .chunk    (chunk_eff),
         .terrain  (terrain_eff),
         .out      (lane_out[a])
      );
   end

   // merge the three lanes into one response beat
   logic [LOCAL_W-1:0] local_ff [NUM_AXES];
   logic [COORD_W-1:0] home_ff  [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lane_out[0].valid & lane_out[1].valid & lane_out[2].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            local_ff[i] <= lane_out[i].local_c;
            home_ff[i]  <= lane_out[i].home;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.local_x      = local_ff[0];
   assign rsp_bus.local_y      = local_ff[1];
   assign rsp_bus.local_z      = local_ff[2];
   assign rsp_bus.home_chunk_x = home_ff[0];
   assign rsp_bus.home_chunk_y = home_ff[1];
   assign rsp_bus.home_chunk_z = home_ff[2];

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (lane_out[0].valid == lane_out[1].valid) && (lane_out[1].valid == lane_out[2].valid))
      else $error("axis lanes out of step");

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(home_ff[0]) && $stable(local_ff[0]))
      else $error("response beat changed while stalled");

endmodule

### design/vtc_div.sv
// Pipelined restoring divider, one quotient bit per stage, by an 8-bit divisor.
// NUMS dividends share the divisor; a sideband rides along. Uses vtc_pkg.
module vtc_div #(
   parameter int N    = 16,
   parameter int NUMS = 1,
   parameter int SW   = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [vtc_pkg::CFG_W-1:0]            den,
   input  logic [NUMS-1:0][N-1:0]               num,
   input  logic [SW-1:0]                        side_in,
   output logic                                 out_valid,
   output logic [NUMS-1:0][N-1:0]               quo,
   output logic [NUMS-1:0][vtc_pkg::CFG_W-1:0]  rem,
   output logic [SW-1:0]                        side_out
);
   import vtc_pkg::*;

   logic [N-1:0]                        valid_ff;
   logic [NUMS-1:0][N-1:0]              nq_ff   [N];
   logic [NUMS-1:0][CFG_W-1:0]          rem_ff  [N];
   logic [SW-1:0]                       side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                        v_src;
      logic [NUMS-1:0][N-1:0]      nq_src;
      logic [NUMS-1:0][CFG_W-1:0]  r_src;
      logic [SW-1:0]               s_src;
      logic [NUMS-1:0][N-1:0]      nq_in;
      logic [NUMS-1:0][CFG_W-1:0]  r_in;

      if (k == 0) begin : g_first
         assign v_src  = in_valid;
         assign nq_src = num;
         assign r_src  = '0;
         assign s_src  = side_in;
      end else begin : g_next
         assign v_src  = valid_ff[k-1];
         assign nq_src = nq_ff[k-1];
         assign r_src  = rem_ff[k-1];
         assign s_src  = side_ff[k-1];
      end

      for (genvar j = 0; j < NUMS; j++) begin : g_num
         logic [CFG_W:0] trial;
         logic [CFG_W:0] diff;
         logic           ge;
         always_comb begin
            trial = {r_src[j], nq_src[j][N-1]};
            diff  = trial - {1'b0, den};
            ge    = (trial >= {1'b0, den});
            r_in[j]  = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            nq_in[j] = {nq_src[j][N-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]   <= nq_in;
            rem_ff[k]  <= r_in;
            side_ff[k] <= s_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign quo       = nq_ff[N-1];
   assign rem       = rem_ff[N-1];
   assign side_out  = side_ff[N-1];

   // while stalled the whole pipe holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("divider pipe moved while stalled");

endmodule

### design/vtc_lane.sv
// One axis lane: home chunk by floor division and the scaled local coordinate.
// Uses vtc_pkg and two vtc_div pipelines.
module vtc_lane #(
   parameter int W = vtc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [vtc_pkg::COORD_W-1:0]   voxel,
   input  logic [vtc_pkg::COORD_W-1:0]   grid,
   input  logic [vtc_pkg::CFG_W-1:0]     chunk,
   input  logic [vtc_pkg::CFG_W-1:0]     terrain,
   output vtc_pkg::lane_out_type         out
);
   import vtc_pkg::*;

   localparam int PW = 2 * CFG_W;

   logic                valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff, valid_e_ff;
   logic [W-1:0]        v_a_ff, g_a_ff, v_b_ff, prod_b_ff, v_c_ff, off_c_ff;
   logic                gneg_b_ff, gneg_c_ff, gneg_d_ff, gneg_e_ff;
   logic [W+CFG_W:0]    prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   assign prod = $signed(g_a_ff) * $signed({1'b0, chunk});

   always_ff @(posedge clock) begin
      if (en) begin
         v_a_ff    <= voxel[W-1:0];
         g_a_ff    <= grid[W-1:0];
         v_b_ff    <= v_a_ff;
         prod_b_ff <= prod[W-1:0];
         gneg_b_ff <= g_a_ff[W-1];
         v_c_ff    <= v_b_ff;
         off_c_ff  <= v_b_ff - prod_b_ff;
         gneg_c_ff <= gneg_b_ff;
      end
   end

   // magnitudes of voxel and offset share one divider pipe
   logic [1:0][W-1:0]       d1_num, d1_quo;
   logic [1:0][CFG_W-1:0]   d1_rem;
   logic [2:0]              d1_side;
   logic                    d1_valid;

   assign d1_num[0] = v_c_ff[W-1]   ? (~v_c_ff + 1'b1)   : v_c_ff;
   assign d1_num[1] = off_c_ff[W-1] ? (~off_c_ff + 1'b1) : off_c_ff;

   vtc_div #(.N(W), .NUMS(2), .SW(3)) u_div_coord (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_c_ff),
      .den       (chunk),
      .num       (d1_num),
      .side_in   ({v_c_ff[W-1], off_c_ff[W-1], gneg_c_ff}),
      .out_valid (d1_valid),
      .quo       (d1_quo),
      .rem       (d1_rem),
      .side_out  (d1_side)
   );

   logic [W-1:0]      home_in, home_d_ff, home_e_ff;
   logic [CFG_W-1:0]  m, x_in, x_d_ff;
   logic [PW-1:0]     p_e_ff;

   always_comb begin
      // floor division: negative voxel with a remainder rounds one further down
      home_in = d1_side[2] ? (~d1_quo[0] + W'(d1_rem[0] == '0)) : d1_quo[0];
      m       = (d1_side[1] && d1_rem[1] != '0) ? (chunk - d1_rem[1]) : d1_rem[1];
      // tail window measures from the chunk end
      x_in    = d1_side[0] ? (chunk - 8'd1 - m) : m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= d1_valid;
         valid_e_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         home_d_ff <= home_in;
         x_d_ff    <= x_in;
         gneg_d_ff <= d1_side[0];
         home_e_ff <= home_d_ff;
         p_e_ff    <= x_d_ff * terrain;
         gneg_e_ff <= gneg_d_ff;
      end
   end

   logic [0:0][PW-1:0]     d2_quo;
   logic [0:0][CFG_W-1:0]  d2_rem;
   logic [W:0]             d2_side;
   logic                   d2_valid;

   vtc_div #(.N(PW), .NUMS(1), .SW(W + 1)) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_e_ff),
      .den       (chunk),
      .num       (p_e_ff),
      .side_in   ({home_e_ff, gneg_e_ff}),
      .out_valid (d2_valid),
      .quo       (d2_quo),
      .rem       (d2_rem),
      .side_out  (d2_side)
   );

   lane_out_type out_ff;
   logic [CFG_W-1:0] q;

   // quotient stays below terrain size, so 8 bits hold it
   assign q = d2_quo[0][CFG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.local_c <= d2_side[0] ? (chunk - 8'd1 - q) : q;
         out_ff.home    <= COORD_W'($signed(d2_side[W:1]));
      end
   end

   assign out = out_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      d2_valid |-> (d2_rem[0] < chunk))
      else $error("scale remainder not below chunk size");

endmodule

### bench/vtc_coord_checker.sv
// Checker for the voxel to chunk-local coordinate unit: tracks the size
// registers, predicts each response beat and compares it in order.
// Depends on vtc_pkg and the vtc_req_if / vtc_rsp_if interfaces.
module vtc_coord_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [vtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vtc_pkg::CFG_W-1:0]     csr_wdata,
   vtc_req_if                            req,
   vtc_rsp_if                            rsp,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import vtc_pkg::*;

   typedef struct {
      logic [LOCAL_W-1:0] local_c [NUM_AXES];
      logic [COORD_W-1:0] home    [NUM_AXES];
   } coord_result_type;

   logic [CFG_W-1:0] chunk_sz [NUM_AXES];
   logic [CFG_W-1:0] terr_sz  [NUM_AXES];
   coord_result_type expected_coords [$];

   // returns {local, home} for one axis
   function automatic logic [LOCAL_W+COORD_W-1:0] map_axis(
      logic [COORD_W-1:0] vin, logic [COORD_W-1:0] gin,
      logic [CFG_W-1:0] cs, logic [CFG_W-1:0] ts);
      longint c, t, v, g, off, m, r, d, p, q;
      logic [COORD_W-1:0] wrapped;
      c = (cs == 0) ? 1 : longint'(cs);
      t = (ts == 0) ? 1 : longint'(ts);
      v = $signed(vin);
      g = $signed(gin);
      wrapped = COORD_W'(v - g * c);
      off = $signed(wrapped);
      m = ((off % c) + c) % c;
      if (g >= 0) begin
         r = (m * t) / c;
      end else begin
         // tail window, measured from the chunk end
         d = (c - 1) - m;
         p = (t - 1) - (d * t) / c;
         r = (c - t) + (p % t);
      end
      q = v / c;
      if (v < 0 && (v % c) != 0) q = q - 1;
      return {r[LOCAL_W-1:0], q[COORD_W-1:0]};
   endfunction

   always @(posedge clock) begin
      coord_result_type exp_r, got;
      logic [LOCAL_W+COORD_W-1:0] ax;
      logic [COORD_W-1:0] vox [NUM_AXES];
      logic [COORD_W-1:0] grd [NUM_AXES];
      string axn;
      if (reset) begin
         foreach (chunk_sz[i]) begin
            chunk_sz[i] = CHUNK_RESET;
            terr_sz[i]  = TERRAIN_RESET;
         end
         expected_coords.delete();
      end else begin
         if (req.valid && req.ready) begin
            vox = '{req.voxel_x, req.voxel_y, req.voxel_z};
            grd = '{req.grid_x, req.grid_y, req.grid_z};
            for (int a = 0; a < NUM_AXES; a++) begin
               ax = map_axis(vox[a], grd[a], chunk_sz[a], terr_sz[a]);
               exp_r.local_c[a] = ax[LOCAL_W+COORD_W-1:COORD_W];
               exp_r.home[a]    = ax[COORD_W-1:0];
            end
            expected_coords.push_back(exp_r);
         end
         if (rsp.valid && rsp.ready) begin
            got.local_c = '{rsp.local_x, rsp.local_y, rsp.local_z};
            got.home    = '{rsp.home_chunk_x, rsp.home_chunk_y, rsp.home_chunk_z};
            if (expected_coords.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               exp_r = expected_coords.pop_front();
               for (int a = 0; a < NUM_AXES; a++) begin
                  axn = (a == 0) ? "x" : (a == 1) ? "y" : "z";
                  if (got.local_c[a] !== exp_r.local_c[a]) begin
                     $error("local_%s: expected %0d, got %0d", axn,
                            exp_r.local_c[a], got.local_c[a]);
                     fail_count++;
                  end
                  if (got.home[a] !== exp_r.home[a]) begin
                     $error("home_chunk_%s: expected %0d, got %0d", axn,
                            $signed(exp_r.home[a]), $signed(got.home[a]));
                     fail_count++;
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_CHUNK_X:   chunk_sz[0] = csr_wdata;
               REG_CHUNK_Y:   chunk_sz[1] = csr_wdata;
               REG_CHUNK_Z:   chunk_sz[2] = csr_wdata;
               REG_TERRAIN_X: terr_sz[0]  = csr_wdata;
               REG_TERRAIN_Y: terr_sz[1]  = csr_wdata;
               REG_TERRAIN_Z: terr_sz[2]  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_coords.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end
endmodule

### bench/tb_voxel_to_chunk_local_coord_unit.sv
// Top of the coordinate unit bench: clock, reset, size register phases and
// request/response traffic. Uses vtc_pkg, the channel interfaces and vtc_coord_checker.
module tb_voxel_to_chunk_local_coord_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import vtc_pkg::*;

   localparam int LATENCY   = COORD_WIDTH_DEF + 23;
   localparam int MAX_CYCLE = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   int                   fail_count, pending;
   int                   cycles = 0;
   bit                   quiet = 1'b0;
   logic [CFG_W-1:0]     cur_chunk [NUM_AXES];

   vtc_req_if req ();
   vtc_rsp_if rsp ();

   voxel_to_chunk_local_coord_unit i_dut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_bus(req), .rsp_bus(rsp)
   );

   vtc_coord_checker i_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req, .rsp, .fail_count, .pending
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLE) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial rsp.ready = 1'b0;
   always @(negedge clock)
      rsp.ready = quiet || ($urandom_range(99) >= 14);

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // drain the pipe, then load all six sizes
   task automatic set_sizes(logic [CFG_W-1:0] cx, cy, cz, tx, ty, tz);
      wait (pending == 0);
      repeat (LATENCY + 4) @(negedge clock);
      write_reg(REG_CHUNK_X, cx);
      write_reg(REG_CHUNK_Y, cy);
      write_reg(REG_CHUNK_Z, cz);
      write_reg(REG_TERRAIN_X, tx);
      write_reg(REG_TERRAIN_Y, ty);
      write_reg(REG_TERRAIN_Z, tz);
      cur_chunk = '{cx, cy, cz};
   endtask

   task automatic send_beat(logic [31:0] vx, vy, vz, gx, gy, gz);
      while (!quiet && $urandom_range(99) < 14) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid   = 1'b1;
      req.voxel_x = vx;
      req.voxel_y = vy;
      req.voxel_z = vz;
      req.grid_x  = gx;
      req.grid_y  = gy;
      req.grid_z  = gz;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(600)) - 300);
         2: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom())} ^ 32'h4000_0000;
         default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   // grid near the voxel's own chunk, where the local frame is meaningful
   function automatic logic [31:0] near_grid(logic [31:0] v, logic [CFG_W-1:0] c);
      longint q;
      q = $signed(v) / longint'((c == 0) ? 1 : c);
      return 32'(q + $signed($urandom_range(4)) - 2);
   endfunction

   task automatic random_items(int n);
      logic [31:0] v [3];
      logic [31:0] g [3];
      for (int k = 0; k < n; k++) begin
         for (int a = 0; a < 3; a++) begin
            v[a] = rand_coord();
            g[a] = ($urandom_range(99) < 70) ? near_grid(v[a], cur_chunk[a]) : rand_coord();
         end
         send_beat(v[0], v[1], v[2], g[0], g[1], g[2]);
      end
   endtask

   initial begin
      logic [31:0] edges [6];
      req.valid = 1'b0;
      req.voxel_x = '0; req.voxel_y = '0; req.voxel_z = '0;
      req.grid_x = '0;  req.grid_y = '0;  req.grid_z = '0;
      cur_chunk = '{CHUNK_RESET, CHUNK_RESET, CHUNK_RESET};
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, negative grids, reset sizes
      edges = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd15, 32'hffff_fff0};
      for (int i = 0; i < 6; i++)
         send_beat(edges[i], edges[(i+1)%6], edges[(i+2)%6],
                   edges[(i+3)%6], edges[(i+4)%6], edges[(i+5)%6]);
      send_beat(-32'sd1, -32'sd17, 32'd33, -32'sd1, -32'sd2, 32'd2);

      // zero sizes count as one; out-of-range indexes are dropped
      set_sizes(8'd0, 8'd1, 8'd255, 8'd0, 8'd255, 8'd1);
      write_reg(3'd6, 8'd3);
      write_reg(3'd7, 8'd9);
      for (int i = 0; i < 6; i++)
         send_beat(edges[i], edges[5-i], 32'd7, edges[(i+2)%6], -32'sd1, edges[i]);

      // tail window wider than the chunk
      set_sizes(8'd3, 8'd1, 8'd7, 8'd200, 8'd255, 8'd9);
      for (int i = 0; i < 6; i++)
         send_beat(-32'sd5 + i, 32'd0, -32'sd300 + i, -32'sd1, -32'sd4, -32'sd40);

      random_items(120);
      set_sizes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      random_items(100);
      set_sizes(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
      quiet = 1'b1;
      random_items(100);
      quiet = 1'b0;
      set_sizes(8'd16, 8'd32, 8'd5, 8'd8, 8'd64, 8'd13);
      random_items(50);
      // hold the sender until the pipe is empty
      wait (pending == 0);
      random_items(50);
      for (int ph = 0; ph < 4; ph++) begin
         set_sizes(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                   CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
         random_items(70);
      end

      wait (pending == 0);
      repeat (LATENCY + 4) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
